// ===== rtl/core/byte_pattern_search_first_last_count_defines.svh =====
// assertion macros for the byte pattern search block
// used by the top level only, no other dependencies
`ifndef BYTE_PATTERN_SEARCH_FIRST_LAST_COUNT_DEFINES_SVH
`define BYTE_PATTERN_SEARCH_FIRST_LAST_COUNT_DEFINES_SVH

// plain property, checked at every edge outside reset
`define BPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent this cycle, consequent next cycle
`define BPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bps_pkg.sv =====
// shared types and constants for the byte pattern search block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

  localparam int unsigned PATTERN_MAX_DEF   = 16;
  localparam int unsigned POSITION_BITS_DEF = 16;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned OFFSET_W   = 16;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned STORED_PATTERN_BYTES = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH = 2'd0,
    CFG_PATTERN_LOW    = 2'd1,
    CFG_PATTERN_HIGH   = 2'd2,
    CFG_SEARCH_MODE    = 2'd3
  } cfg_reg_e;

  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LAST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COUNT = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] match_offset;
    logic [COUNT_W-1:0]  match_count;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/core/bps_match.sv =====
// parallel compare of the byte window against the aligned pattern
// depends on bps_pkg
`timescale 1ns / 1ps
`default_nettype none

module bps_match
  import bps_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  wire logic [PATTERN_MAX-1:0][7:0] window_i,
  input  wire logic [PATTERN_MAX-1:0][7:0] pattern_i,
  input  wire logic [LEN_W-1:0]            len_i,
  output logic                             hit_o
);

  logic [PATTERN_MAX-1:0][7:0] sel;
  logic [PATTERN_MAX-1:0]      lane_ok;

  // window entry k (newest first) meets pattern byte len-1-k
  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      sel[k] = '0;
      for (int j = 0; j < PATTERN_MAX; j++) begin
        if (32'(j) + 32'(k) + 32'd1 == 32'(len_i)) begin
          sel[k] = pattern_i[j];
        end
      end
      lane_ok[k] = (32'(k) >= 32'(len_i)) || (window_i[k] == sel[k]);
    end
  end

  assign hit_o = &lane_ok;

endmodule

`default_nettype wire

// ===== rtl/core/byte_pattern_search_first_last_count.sv =====
// top level of the byte pattern search: first match, last match or match count
// depends on bps_pkg, bps_match and byte_pattern_search_first_last_count_defines.svh
`timescale 1ns / 1ps
`default_nettype none

//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------------
//  in       | input     | in_valid_i / in_stall_o | in_t  : data_byte, final_byte
//  out      | output    | out_valid_o / out_stall_i | out_t : found, offset, count
//  cfg      | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
//  one byte per cycle while no output stall holds it: a transfer lands in the input register, then
//  the window compare and stream update run from it and a final byte loads the result register
//  reset clears configuration to length 1, zero pattern, first-match mode
//  an output stall on a held result keeps the input register, and the input stalls only while that register is full

`include "byte_pattern_search_first_last_count_defines.svh"

module byte_pattern_search_first_last_count
  import bps_pkg::*;
#(
  parameter int unsigned PATTERN_MAX   = PATTERN_MAX_DEF,
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration writes
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // source bytes
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_t                   in_data_i,
  // results
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_t                       out_data_o
);

  localparam int unsigned FILL_W = $clog2(PATTERN_MAX + 1);

  // configuration registers
  logic [LEN_W-1:0]      pat_len_q;
  logic [CFG_DATA_W-1:0] pat_low_q;
  logic [CFG_DATA_W-1:0] pat_high_q;
  logic [MODE_W-1:0]     mode_q;

  // input register
  logic s1_valid_q;
  in_t  s1_data_q;

  // stream state
  logic [PATTERN_MAX-1:0][7:0] win_q, win_d;
  logic [FILL_W-1:0]           fill_q, fill_d;
  logic [POSITION_BITS-1:0]    pos_q, pos_d;
  logic                        seen_q, seen_d;
  logic [POSITION_BITS-1:0]    rec_q, rec_d;
  logic [COUNT_W-1:0]          total_q, total_d;
  logic [LEN_W-1:0]            skip_q, skip_d;

  // result register
  logic out_valid_q;
  out_t out_data_q, out_data_d;

  logic                        out_ready;
  logic                        advance;
  logic [LEN_W-1:0]            eff_len;
  logic [PATTERN_MAX-1:0][7:0] pattern;
  logic                        lanes_hit;
  logic                        hit;
  logic                        counting;
  logic [POSITION_BITS-1:0]    start_pos;

  // ---------------------------------------------------------------------------
  // handshake: the compare stage moves whenever the result register can take
  // ---------------------------------------------------------------------------
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q  <= LEN_W'(1);
      pat_low_q  <= '0;
      pat_high_q <= '0;
      mode_q     <= MODE_FIRST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_PATTERN_LENGTH: pat_len_q  <= cfg_data_i[LEN_W-1:0];
        CFG_PATTERN_LOW:    pat_low_q  <= cfg_data_i;
        CFG_PATTERN_HIGH:   pat_high_q <= cfg_data_i;
        CFG_SEARCH_MODE:    mode_q     <= cfg_data_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // zero length acts as one, lengths past the window are clipped
  always_comb begin
    if (pat_len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(pat_len_q) > PATTERN_MAX) begin
      eff_len = LEN_W'(PATTERN_MAX);
    end else begin
      eff_len = pat_len_q;
    end
  end

  // pattern bytes from the two words, bytes past the stored sixteen read zero
  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      if (j < 8) begin
        pattern[j] = 8'(pat_low_q >> (8 * j));
      end else if (j < STORED_PATTERN_BYTES) begin
        pattern[j] = 8'(pat_high_q >> (8 * (j - 8)));
      end else begin
        pattern[j] = '0;
      end
    end
  end

  // modes other than first and last count matches
  assign counting = (mode_q != MODE_FIRST) && (mode_q != MODE_LAST);

  // ---------------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_data_q <= in_data_i;
    end
  end

  // ---------------------------------------------------------------------------
  // window shift and compare
  // ---------------------------------------------------------------------------
  always_comb begin
    win_d[0] = s1_data_q.data_byte;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      win_d[k] = win_q[k-1];
    end
  end

  // fill count saturates at the window depth
  assign fill_d = (fill_q == FILL_W'(PATTERN_MAX)) ? fill_q : fill_q + 1'b1;

  bps_match #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_match (
    .window_i (win_d),
    .pattern_i(pattern),
    .len_i    (eff_len),
    .hit_o    (lanes_hit)
  );

  // a match needs a full pattern length of bytes from this source
  assign hit       = lanes_hit && (32'(fill_d) >= 32'(eff_len));
  assign start_pos = pos_q - POSITION_BITS'(eff_len - LEN_W'(1));

  // ---------------------------------------------------------------------------
  // stream update and result
  // ---------------------------------------------------------------------------
  always_comb begin
    pos_d   = pos_q + 1'b1;
    seen_d  = seen_q || hit;
    rec_d   = rec_q;
    total_d = total_q;
    skip_d  = skip_q;

    if (hit && ((mode_q == MODE_LAST) || ((mode_q == MODE_FIRST) && !seen_q))) begin
      rec_d = start_pos;
    end

    // non-overlapping count: bytes of the last counted match are skipped
    if (skip_q != '0) begin
      skip_d = skip_q - 1'b1;
    end else if (hit) begin
      if (total_q != COUNT_MAX) begin
        total_d = total_q + 1'b1;
      end
      skip_d = eff_len - LEN_W'(1);
    end

    out_data_d.found        = seen_d;
    out_data_d.match_offset = (!counting && seen_d) ? OFFSET_W'(rec_d) : '0;
    out_data_d.match_count  = counting ? total_d : '0;
  end

  // control part of the stream state, cleared after every final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      pos_q   <= '0;
      seen_q  <= 1'b0;
      rec_q   <= '0;
      total_q <= '0;
      skip_q  <= '0;
    end else if (advance) begin
      if (s1_data_q.final_byte) begin
        fill_q  <= '0;
        pos_q   <= '0;
        seen_q  <= 1'b0;
        rec_q   <= '0;
        total_q <= '0;
        skip_q  <= '0;
      end else begin
        fill_q  <= fill_d;
        pos_q   <= pos_d;
        seen_q  <= seen_d;
        rec_q   <= rec_d;
        total_q <= total_d;
        skip_q  <= skip_d;
      end
    end
  end

  // window bytes are only read once the fill count covers them
  always_ff @(posedge clk_i) begin
    if (advance) begin
      win_q <= win_d;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && s1_data_q.final_byte) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_data_q.final_byte) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `BPS_ASSERT(a_stall_only_when_full, clk_i, rst_ni, !in_stall_o || s1_valid_q, "input stalled with empty input register")
  `BPS_ASSERT_NEXT(a_final_clears, clk_i, rst_ni, advance && s1_data_q.final_byte, (pos_q == '0) && !seen_q && (fill_q == '0) && (total_q == '0), "stream state not cleared after final byte")
  `BPS_ASSERT_NEXT(a_count_step, clk_i, rst_ni, advance && !s1_data_q.final_byte, (total_q == $past(total_q)) || (total_q == $past(total_q) + 1'b1), "match count moved by more than one")
  `BPS_ASSERT(a_result_source, clk_i, rst_ni, !$rose(out_valid_q) || $past(advance && s1_data_q.final_byte), "result raised without a final byte")
  `BPS_ASSERT(a_no_match_empty, clk_i, rst_ni, !(out_valid_o && !out_data_o.found) || ((out_data_o.match_offset == '0) && (out_data_o.match_count == '0)), "result without a match carries offset or count")

endmodule

`default_nettype wire

// ===== tb/byte_pattern_search_first_last_count_tb.sv =====
// self-checking testbench for byte_pattern_search_first_last_count: streams source bytes,
// writes the search registers between phases and checks every first, last or count result
// depends on bps_pkg and the top level of the block
`timescale 1ns / 1ps

module byte_pattern_search_first_last_count_tb;
  import bps_pkg::*;

  localparam int unsigned CLK_HALF      = 5;
  localparam int unsigned RESET_CYCLES  = 10;
  // idle time after the last result so that the input and result registers are empty
  localparam int unsigned DRAIN_CYCLES  = 6;
  localparam int unsigned MAX_WAIT      = 11;
  localparam int unsigned RANDOM_BYTES  = 1350;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned WINDOW_BYTES  = PATTERN_MAX_DEF;
  localparam int unsigned LEN_CODE_MAX  = (1 << LEN_W) - 1;
  localparam longint unsigned CYCLE_LIMIT = 200_000;
  // spare mode encoding, the block treats it as count mode
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  // predicts the search result of each source and holds the results still to come
  class search_result_checker;
    logic [LEN_W-1:0]             len_reg;
    logic [CFG_DATA_W-1:0]        low_reg;
    logic [CFG_DATA_W-1:0]        high_reg;
    logic [MODE_W-1:0]            mode_reg;
    logic [7:0]                   recent [WINDOW_BYTES];
    int unsigned                  fill;
    logic [POSITION_BITS_DEF-1:0] position;
    bit                           seen;
    logic [POSITION_BITS_DEF-1:0] recorded;
    logic [COUNT_W-1:0]           total;
    int unsigned                  skip;
    out_t                         expected_results [$];
    int unsigned                  mismatches;
    int unsigned                  checked;

    function new();
      len_reg    = 1;
      low_reg    = '0;
      high_reg   = '0;
      mode_reg   = MODE_FIRST;
      mismatches = 0;
      checked    = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      foreach (recent[i]) recent[i] = '0;
      fill     = 0;
      position = '0;
      seen     = 1'b0;
      recorded = '0;
      total    = '0;
      skip     = 0;
    endfunction

    function void apply_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_PATTERN_LENGTH: len_reg  = value[LEN_W-1:0];
        CFG_PATTERN_LOW:    low_reg  = value;
        CFG_PATTERN_HIGH:   high_reg = value;
        CFG_SEARCH_MODE:    mode_reg = value[MODE_W-1:0];
        default: ;
      endcase
    endfunction

    // length zero acts as one, lengths past the window act as the full window
    function int unsigned effective_length();
      int unsigned len;
      len = len_reg;
      if (len == 0) len = 1;
      if (len > WINDOW_BYTES) len = WINDOW_BYTES;
      return len;
    endfunction

    function logic [7:0] pattern_at(int unsigned idx);
      logic [2*CFG_DATA_W-1:0] both;
      both = {high_reg, low_reg};
      return both[8*idx +: 8];
    endfunction

    function void note_byte(in_t item);
      int unsigned                  len;
      int unsigned                  k;
      bit                           hit;
      bit                           counting;
      logic [POSITION_BITS_DEF-1:0] start;
      out_t                         res;
      len      = effective_length();
      counting = (mode_reg == MODE_COUNT) || (mode_reg == MODE_SPARE);
      for (k = WINDOW_BYTES - 1; k > 0; k--) recent[k] = recent[k-1];
      recent[0] = item.data_byte;
      if (fill < WINDOW_BYTES) fill++;
      // a match needs a full pattern's worth of bytes from this source
      hit = (fill >= len);
      for (k = 0; k < len; k++)
        if (hit && recent[k] != pattern_at(len - 1 - k)) hit = 1'b0;
      if (hit) begin
        start = position - POSITION_BITS_DEF'(len - 1);
        if (mode_reg == MODE_LAST || (mode_reg == MODE_FIRST && !seen)) recorded = start;
        seen = 1'b1;
      end
      // non-overlapping count: bytes of the last counted match are skipped
      if (skip > 0) begin
        skip--;
      end else if (hit) begin
        if (total != COUNT_MAX) total++;
        skip = len - 1;
      end
      position++;
      if (item.final_byte) begin
        res.found        = seen;
        res.match_offset = (!counting && seen) ? recorded : '0;
        res.match_count  = counting ? total : '0;
        expected_results.push_back(res);
        clear_stream();
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: found %0d offset %0d count %0d",
                   got.found, got.match_offset, got.match_count);
        return;
      end
      want = expected_results.pop_front();
      if (got.found !== want.found || got.match_offset !== want.match_offset ||
          got.match_count !== want.match_count) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result %0d wrong: expected found %0d offset %0d count %0d, got found %0d offset %0d count %0d",
                   checked, want.found, want.match_offset, want.match_count,
                   got.found, got.match_offset, got.match_count);
      end
      checked++;
    endfunction
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  cfg_reg_e              cfg_idx_i   = CFG_PATTERN_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_t                   in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_t                  out_data_o;

  search_result_checker  result_check;
  // longest wait per transfer on each side, changed from phase to phase
  int unsigned           tx_max_gap  = 0;
  int unsigned           rx_max_hold = 0;
  int unsigned           hold_left   = 0;
  int unsigned           bytes_sent  = 0;
  longint unsigned       cycle_count = 0;

  byte_pattern_search_first_last_count DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // result side: check each transfer, then hold off for a freshly drawn number of cycles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        result_check.check_result(out_data_o);
        hold_left = $urandom_range(0, rx_max_hold);
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_stall_i <= (hold_left > 0);
    end
  end

  // guard against a hung handshake or a result that never comes
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // one source byte: optional gap with valid low, then hold until the transfer
  task automatic send_byte(input logic [7:0] value, input logic last);
    int unsigned gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{data_byte: value, final_byte: last};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    result_check.note_byte(in_data_i);
    bytes_sent++;
  endtask

  // stop the source, let every expected result arrive and the pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (result_check.expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // caller lowers the write enable after the last write of a burst
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    result_check.apply_reg(idx, value);
    @(posedge clk_i);
  endtask

  // unused upper bits of the length and mode words carry junk on purpose
  task automatic load_search(input logic [LEN_W-1:0] len, input logic [CFG_DATA_W-1:0] low,
                             input logic [CFG_DATA_W-1:0] high, input logic [MODE_W-1:0] mode);
    logic [CFG_DATA_W-1:0] junk;
    junk = {$urandom, $urandom};
    write_reg(CFG_PATTERN_LENGTH, {junk[CFG_DATA_W-1:LEN_W], len});
    write_reg(CFG_PATTERN_LOW, low);
    write_reg(CFG_PATTERN_HIGH, high);
    write_reg(CFG_SEARCH_MODE, {junk[CFG_DATA_W-1:MODE_W], mode});
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    case ($urandom_range(0, 5))
      0:       return LEN_W'($urandom_range(0, 2));
      1, 2:    return LEN_W'($urandom_range(1, 8));
      3:       return LEN_W'($urandom_range(9, WINDOW_BYTES));
      4:       return LEN_W'(WINDOW_BYTES);
      default: return LEN_W'($urandom_range(WINDOW_BYTES + 1, LEN_CODE_MAX));
    endcase
  endfunction

  // small alphabets make chance matches common, all-zero and all-one words are the extremes
  function automatic logic [CFG_DATA_W-1:0] pick_pattern_word();
    logic [CFG_DATA_W-1:0] word;
    case ($urandom_range(0, 4))
      0:       word = '0;
      1:       word = '1;
      2:       word = {$urandom, $urandom};
      default: begin
        for (int i = 0; i < CFG_DATA_W / 8; i++)
          word[8*i +: 8] = 8'(8'hA0 + $urandom_range(0, 2));
      end
    endcase
    return word;
  endfunction

  // one source built from pattern copies (some spoiled), pattern bytes and noise
  task automatic send_random_source();
    logic [7:0]  src [$];
    int unsigned len;
    int unsigned target;
    int unsigned spoil;
    int unsigned swap_at;
    int unsigned j;
    bit          noise;
    len    = result_check.effective_length();
    target = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 120) : $urandom_range(1, 40);
    noise  = ($urandom_range(0, 9) == 0);
    while (src.size() < target) begin
      if (!noise && $urandom_range(0, 3) == 0) begin
        spoil = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : len;
        for (j = 0; j < len; j++)
          src.push_back(j == spoil ? ~result_check.pattern_at(j) : result_check.pattern_at(j));
      end else if (!noise && $urandom_range(0, 1) == 0) begin
        src.push_back(result_check.pattern_at($urandom_range(0, len - 1)));
      end else begin
        src.push_back(8'($urandom));
      end
    end
    // now and then the mode changes part way through the source
    swap_at = ($urandom_range(0, 19) == 0 && src.size() > 1) ? $urandom_range(1, src.size() - 1)
                                                             : src.size();
    for (j = 0; j < src.size(); j++) begin
      if (j == swap_at) begin
        settle();
        write_reg(CFG_SEARCH_MODE, CFG_DATA_W'($urandom_range(0, MODE_SPARE)));
        cfg_we_i <= 1'b0;
      end
      send_byte(src[j], j == src.size() - 1);
    end
  endtask

  initial begin
    int unsigned random_goal;
    result_check = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, with full idling on both sides
    tx_max_gap  = MAX_WAIT;
    rx_max_hold = MAX_WAIT;
    // reset values: length 1, zero pattern, first match
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    settle();
    // length zero behaves as one, last match
    load_search(5'd0, 64'hAB, '0, MODE_LAST);
    send_byte(8'hAB, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'hAB, 1'b1);
    settle();
    // spare mode counts
    write_reg(CFG_SEARCH_MODE, CFG_DATA_W'(MODE_SPARE));
    cfg_we_i <= 1'b0;
    send_byte(8'hAB, 1'b0);
    send_byte(8'hAB, 1'b0);
    send_byte(8'hAB, 1'b1);
    settle();
    // overlapping runs count once per non-overlapping match
    load_search(5'd2, 64'hABAB, '0, MODE_COUNT);
    repeat (4) send_byte(8'hAB, 1'b0);
    send_byte(8'hAB, 1'b1);
    settle();
    // short history: the tail of the previous source must not complete a match
    load_search(5'd3, 64'h030201, '0, MODE_FIRST);
    send_byte(8'h01, 1'b1);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b1);
    settle();
    // mode switched from first to last part way through a source
    load_search(5'd1, 64'h5A, '1, MODE_FIRST);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h00, 1'b0);
    settle();
    write_reg(CFG_SEARCH_MODE, CFG_DATA_W'(MODE_LAST));
    cfg_we_i <= 1'b0;
    send_byte(8'h5A, 1'b0);
    send_byte(8'h5A, 1'b1);
    settle();

    // random sources, with fresh registers and idling levels every few sources
    random_goal = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < random_goal) begin
      if ($urandom_range(0, 2) == 0) begin
        settle();
        tx_max_gap  = ($urandom_range(0, 3) == 0) ? 0 : MAX_WAIT;
        rx_max_hold = ($urandom_range(0, 3) == 0) ? 0 : MAX_WAIT;
        load_search(pick_length(), pick_pattern_word(), pick_pattern_word(),
                    MODE_W'($urandom_range(0, MODE_SPARE)));
      end
      send_random_source();
    end

    settle();
    if (result_check.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
